// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; define ASSERT_OFF to drop.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// check prop on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check prop on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== rtl/dttb_pkg.sv =====
// ----------------------------------------------------------------------------
// dttb_pkg
// Types, constants and the power-of-ten scaling table of the converter.
// ----------------------------------------------------------------------------
package dttb_pkg;

  // largest mantissa that can still take one more decimal digit
  localparam logic [63:0] MANT_LIMIT = 64'h1999_9999_9999_9998;
  localparam int EXP_TOP    = 310;
  localparam int EXP_BOTTOM = -345;

  // one row of the scaling table
  typedef struct packed {
    logic [63:0]        hm;
    logic [7:0]         lo8;
    logic [5:0]         dec;
    logic signed [8:0]  bin;
  } row_t;

  // controller to datapath commands
  typedef struct packed {
    logic       idle;
    logic       norm_en;
    logic       sel_en;
    logic       mul_en;
    logic [2:0] step;
    logic       pack1_en;
    logic       pack2_en;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic start;
    logic mexp_zero;
    logic mul_more;
    logic out_free;
  } stat_t;

  // scaling rows: down selects division, idx the coarse to fine step
  function automatic row_t scale_row(input logic down, input logic [1:0] idx);
    row_t r;
    r = '0;
    case ({down, idx})
      3'b000:  r = '{64'hFC6F_7C40_4581_2296, 8'h4D, 6'd31, 9'sd103};
      3'b001:  r = '{64'hFA00_0000_0000_0000, 8'h00, 6'd3, 9'sd10};
      3'b100:  r = '{64'hE45C_10C4_2A2B_3B05, 8'h8D, 6'd44, -9'sd146};
      3'b101:  r = '{64'hD6BF_94D5_E57A_42BC, 8'h3D, 6'd7, -9'sd23};
      3'b110:  r = '{64'hCCCC_CCCC_CCCC_CCCC, 8'hCD, 6'd1, -9'sd3};
      default: r = '{64'hA000_0000_0000_0000, 8'h00, 6'd1, 9'sd4};
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/dttb_ctrl.sv =====
// ----------------------------------------------------------------------------
// dttb_ctrl
// Sequencer for normalize, row select, multiply and pack steps of the final scaling.
// ----------------------------------------------------------------------------
module dttb_ctrl
  import dttb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NORM  = 3'd1;
  localparam logic [2:0] S_SEL   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_PACK1 = 3'd4;
  localparam logic [2:0] S_PACK2 = 3'd5;

  localparam logic [2:0] NORM_LAST = 3'd5;
  localparam logic [2:0] MUL_LAST  = 3'd7;

  logic [2:0] state, state_next;
  logic [2:0] cnt, cnt_next;

  // advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // decode commands and next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.step   = cnt;
    unique case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (st.start) begin
          state_next = S_NORM;
          cnt_next   = '0;
        end
      end
      S_NORM: begin
        cmd.norm_en = 1'b1;
        cnt_next    = cnt + 3'd1;
        if (cnt == NORM_LAST) begin
          state_next = S_SEL;
          cnt_next   = '0;
        end
      end
      S_SEL: begin
        if (st.mexp_zero) begin
          state_next = S_PACK1;
        end else begin
          cmd.sel_en = 1'b1;
          state_next = S_MUL;
          cnt_next   = '0;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        cnt_next   = cnt + 3'd1;
        if (cnt == MUL_LAST) begin
          cnt_next   = '0;
          state_next = st.mul_more ? S_MUL : S_NORM;
        end
      end
      S_PACK1: begin
        cmd.pack1_en = 1'b1;
        state_next   = S_PACK2;
      end
      S_PACK2: begin
        cmd.pack2_en = st.out_free;
        if (st.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/dttb_dp.sv =====
// ----------------------------------------------------------------------------
// dttb_dp
// Character parser, scaling datapath with one shared multiplier, and packer.
// ----------------------------------------------------------------------------
module dttb_dp
  import dttb_pkg::*;
#(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output stat_t                   st,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              char_code,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [63:0]             value_bits,
  output logic [OFFSET_WIDTH-1:0] end_offset,
  output logic                    converted
);

  localparam logic [2:0] PH_SPACE  = 3'd0;
  localparam logic [2:0] PH_INT    = 3'd1;
  localparam logic [2:0] PH_FRACT  = 3'd2;
  localparam logic [2:0] PH_EMARK  = 3'd3;
  localparam logic [2:0] PH_EFIRST = 3'd4;
  localparam logic [2:0] PH_EDIG   = 3'd5;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [19:0] F20_MAX = 20'hF_FFFF;
  localparam logic [OFFSET_WIDTH-1:0] OFS_MAX = '1;

  localparam logic [1:0] CLS_NORMAL = 2'd0;
  localparam logic [1:0] CLS_INF    = 2'd1;
  localparam logic [1:0] CLS_ZERO   = 2'd2;

  localparam logic [63:0] INF_BITS = {1'b0, 11'h7FF, 52'b0};

  // parser registers
  logic [2:0]              phase;
  logic                    negative_flag;
  logic [63:0]             mantissa_accum;
  logic signed [19:0]      decimal_exponent;
  logic                    sticky_digits;
  logic                    digit_seen;
  logic                    exp_negative;
  logic [19:0]             exp_accum;
  logic [19:0]             exp_limit;
  logic [OFFSET_WIDTH-1:0] char_count;
  logic [OFFSET_WIDTH-1:0] end_mark;

  logic [2:0]              phase_next;
  logic                    negative_next;
  logic [63:0]             mant_next;
  logic signed [19:0]      dexp_next;
  logic                    sticky_next;
  logic                    seen_next;
  logic                    eneg_next;
  logic [19:0]             eacc_next;
  logic [19:0]             elim_next;
  logic [OFFSET_WIDTH-1:0] count_next;
  logic [OFFSET_WIDTH-1:0] end_next;

  logic               emit, emit_ok, use_exp, do_reset;
  logic signed [21:0] emit_e;
  logic               emit_scale;
  logic [63:0]        direct_bits;

  logic accept, out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = cmd.idle && out_free;
  assign accept   = in_valid && in_ready;

  // parse one character
  always_comb begin
    logic go_int, go_e, int_mode, is_dig, took, edig_mode;
    logic [3:0] dig;
    logic signed [20:0] de;
    logic signed [21:0] lim;
    logic [23:0] v;
    go_int = 1'b0;
    go_e = 1'b0;
    int_mode = 1'b0;
    edig_mode = 1'b0;
    took = 1'b0;
    de = '0;
    lim = '0;
    v = '0;
    is_dig = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    dig = char_code[3:0];
    phase_next = phase;
    negative_next = negative_flag;
    mant_next = mantissa_accum;
    dexp_next = decimal_exponent;
    sticky_next = sticky_digits;
    seen_next = digit_seen;
    eneg_next = exp_negative;
    eacc_next = exp_accum;
    elim_next = exp_limit;
    end_next = end_mark;
    count_next = (char_count < OFS_MAX) ? char_count + 1'b1 : char_count;
    emit = 1'b0;
    emit_ok = 1'b0;
    use_exp = 1'b0;
    do_reset = 1'b0;

    unique case (phase)
      PH_SPACE: begin
        if (!(char_code >= 8'd1 && char_code <= CH_SPACE)) begin
          phase_next = PH_INT;
          if (char_code == CH_MINUS) begin
            negative_next = 1'b1;
          end else if (char_code != CH_PLUS) begin
            go_int = 1'b1;
            int_mode = 1'b1;
          end
        end
      end
      PH_INT: begin
        go_int = 1'b1;
        int_mode = 1'b1;
      end
      PH_FRACT: begin
        go_int = 1'b1;
      end
      PH_EMARK: begin
        phase_next = PH_EFIRST;
        eneg_next = (char_code == CH_MINUS);
        lim = (char_code == CH_MINUS)
            ? 22'sd345 + {{2{decimal_exponent[19]}}, decimal_exponent}
            : 22'sd310 - {{2{decimal_exponent[19]}}, decimal_exponent};
        if (lim < 0) begin
          elim_next = '0;
        end else if (lim > $signed({2'b0, F20_MAX})) begin
          elim_next = F20_MAX;
        end else begin
          elim_next = lim[19:0];
        end
        eacc_next = '0;
        go_e = (char_code != CH_MINUS) && (char_code != CH_PLUS);
      end
      PH_EFIRST: begin
        go_e = 1'b1;
      end
      PH_EDIG: begin
        go_e = 1'b1;
        edig_mode = 1'b1;
      end
      default: begin
        do_reset = 1'b1;
      end
    endcase

    // mantissa digits, point and end of mantissa
    if (go_int) begin
      if (is_dig) begin
        seen_next = 1'b1;
        took = (mantissa_accum <= MANT_LIMIT);
        if (took) begin
          mant_next = (mantissa_accum << 3) + (mantissa_accum << 1) + {60'b0, dig};
        end else if (dig != 4'd0) begin
          sticky_next = 1'b1;
        end
        de = {decimal_exponent[19], decimal_exponent} + (int_mode ? 21'sd1 : 21'sd0)
           - (took ? 21'sd1 : 21'sd0);
        if (de > 21'sd524287) begin
          dexp_next = 20'sd524287;
        end else if (de < -21'sd524288) begin
          dexp_next = -20'sd524288;
        end else begin
          dexp_next = de[19:0];
        end
      end else if (int_mode && char_code == CH_DOT) begin
        phase_next = PH_FRACT;
      end else if (!digit_seen) begin
        emit = 1'b1;
      end else begin
        end_next = char_count;
        if (char_code == CH_E_LO || char_code == CH_E_UP) begin
          phase_next = PH_EMARK;
        end else begin
          emit = 1'b1;
          emit_ok = 1'b1;
        end
      end
    end

    // exponent digits and end of exponent
    if (go_e) begin
      if (is_dig) begin
        if (eacc_next <= elim_next) begin
          v = ({4'b0, eacc_next} << 3) + ({4'b0, eacc_next} << 1) + {20'b0, dig};
          eacc_next = (v > {4'b0, F20_MAX}) ? F20_MAX : v[19:0];
        end
        phase_next = PH_EDIG;
      end else begin
        emit = 1'b1;
        emit_ok = 1'b1;
        if (edig_mode) begin
          end_next = char_count;
          use_exp = 1'b1;
        end
      end
    end

    // final decimal exponent and routing
    emit_e = {{2{decimal_exponent[19]}}, decimal_exponent};
    if (use_exp) begin
      emit_e = eneg_next ? emit_e - $signed({2'b0, eacc_next})
                         : emit_e + $signed({2'b0, eacc_next});
    end
    emit_scale = emit && emit_ok && (mantissa_accum != 64'b0)
              && (emit_e > 22'(EXP_BOTTOM)) && (emit_e < 22'(EXP_TOP));
    direct_bits = '0;
    if (emit_ok) begin
      if (mantissa_accum != 64'b0 && emit_e >= 22'(EXP_TOP)) begin
        direct_bits = INF_BITS;
      end
      direct_bits[63] = negative_flag;
    end
  end

  // hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_SPACE;
      negative_flag    <= 1'b0;
      mantissa_accum   <= '0;
      decimal_exponent <= '0;
      sticky_digits    <= 1'b0;
      digit_seen       <= 1'b0;
      exp_negative     <= 1'b0;
      exp_accum        <= '0;
      exp_limit        <= '0;
      char_count       <= '0;
      end_mark         <= '0;
    end else if (accept) begin
      if (emit || do_reset) begin
        phase            <= PH_SPACE;
        negative_flag    <= 1'b0;
        mantissa_accum   <= '0;
        decimal_exponent <= '0;
        sticky_digits    <= 1'b0;
        digit_seen       <= 1'b0;
        exp_negative     <= 1'b0;
        exp_accum        <= '0;
        exp_limit        <= '0;
        char_count       <= '0;
        end_mark         <= '0;
      end else begin
        phase            <= phase_next;
        negative_flag    <= negative_next;
        mantissa_accum   <= mant_next;
        decimal_exponent <= dexp_next;
        sticky_digits    <= sticky_next;
        digit_seen       <= seen_next;
        exp_negative     <= eneg_next;
        exp_accum        <= eacc_next;
        exp_limit        <= elim_next;
        char_count       <= count_next;
        end_mark         <= end_next;
      end
    end
  end

  // scaling registers
  logic [63:0]             w1, w0;
  logic signed [13:0]      bine;
  logic [8:0]              mexp;
  logic                    down;
  row_t                    row;
  logic [127:0]            acc;
  logic [63:0]             preg;
  logic [1:0]              psh;
  logic                    sc_sign, sc_sticky;
  logic [OFFSET_WIDTH-1:0] sc_offset;
  logic [63:0]             pk_mant;
  logic [10:0]             pk_exp;
  logic [1:0]              pk_cls;

  // normalization step of 32, 16, 8, 4, 2 or 1 bits
  logic [6:0]   norm_k;
  logic         norm_top_zero;
  logic [127:0] norm_shift;
  assign norm_k        = 7'd32 >> cmd.step;
  assign norm_top_zero = (w1 >> (7'd64 - norm_k)) == 64'b0;
  assign norm_shift    = {w1, w0} << norm_k;

  // row choice and loop status
  logic [1:0] row_idx;
  logic [8:0] mexp_left;
  row_t       row_c0, row_c1;
  assign row_c0 = scale_row(down, 2'd0);
  assign row_c1 = scale_row(down, 2'd1);
  always_comb begin
    if ({3'b0, row_c0.dec} <= mexp) begin
      row_idx = 2'd0;
    end else if ({3'b0, row_c1.dec} <= mexp) begin
      row_idx = 2'd1;
    end else begin
      row_idx = 2'd2;
    end
  end
  assign mexp_left    = mexp - {3'b0, row.dec};
  assign st.start     = accept && emit_scale;
  assign st.mexp_zero = (mexp == 9'd0);
  assign st.mul_more  = (mexp_left >= {3'b0, row.dec});
  assign st.out_free  = out_free;

  // partial product for the current multiply step
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  prod;
  logic [1:0]   prod_sh;
  logic [127:0] preg_ext;
  always_comb begin
    mul_a = w1[31:0];
    mul_b = row.hm[31:0];
    prod_sh = 2'd0;
    case (cmd.step)
      3'd1: begin
        mul_b = row.hm[63:32];
        prod_sh = 2'd1;
      end
      3'd2: begin
        mul_a = w1[63:32];
        prod_sh = 2'd1;
      end
      3'd3: begin
        mul_a = w1[63:32];
        mul_b = row.hm[63:32];
        prod_sh = 2'd2;
      end
      3'd4: begin
        mul_a = w0[63:32];
        mul_b = row.hm[63:32];
      end
      default: begin
      end
    endcase
    if (cmd.step == 3'd5) begin
      prod = {8'b0, w1[63:8]} * {56'b0, row.lo8};
    end else begin
      prod = {32'b0, mul_a} * {32'b0, mul_b};
    end
    preg_ext = {64'b0, preg} << {psh, 5'b0};
  end

  // packing: sticky jam, range and subnormal shift
  logic [63:0]        wj, jmask;
  logic signed [13:0] pe;
  logic [5:0]         dn;
  assign wj    = w1 | {63'b0, (|w0[63:54]) | sc_sticky};
  assign pe    = bine + 14'sd1023;
  assign dn    = 6'(14'sd1 - pe);
  assign jmask = ~(64'hFFFF_FFFF_FFFF_FFFF << dn);

  // rounding to nearest even
  logic [63:0] rnd_ret, rnd_bits;
  logic [10:0] rnd_rem;
  always_comb begin
    rnd_ret = {12'b0, pk_mant[62:11]} | {1'b0, pk_exp, 52'b0};
    rnd_rem = {pk_mant[10:1], pk_mant[0] | pk_mant[11]};
    if (rnd_rem > 11'h400) begin
      rnd_ret = rnd_ret + 64'd1;
    end
    case (pk_cls)
      CLS_INF:  rnd_bits = INF_BITS;
      CLS_ZERO: rnd_bits = '0;
      default:  rnd_bits = rnd_ret;
    endcase
    rnd_bits[63] = sc_sign;
  end

  // run the scaling steps
  always_ff @(posedge clk) begin
    if (st.start) begin
      w1        <= mantissa_accum;
      w0        <= '0;
      bine      <= 14'sd63;
      down      <= emit_e[21];
      mexp      <= emit_e[21] ? 9'(-emit_e) : emit_e[8:0];
      sc_sign   <= negative_flag;
      sc_sticky <= sticky_digits;
      sc_offset <= end_next;
    end
    if (cmd.norm_en && norm_top_zero) begin
      w1   <= norm_shift[127:64];
      w0   <= norm_shift[63:0];
      bine <= bine - 14'(norm_k);
    end
    if (cmd.sel_en) begin
      row <= scale_row(down, row_idx);
    end
    if (cmd.mul_en) begin
      if (cmd.step <= 3'd5) begin
        preg <= prod;
        psh  <= prod_sh;
      end
      if (cmd.step == 3'd1) begin
        acc <= preg_ext;
      end else if (cmd.step >= 3'd2 && cmd.step <= 3'd6) begin
        acc <= acc + preg_ext;
      end else if (cmd.step == 3'd7) begin
        w1   <= acc[127:64];
        w0   <= acc[63:0];
        bine <= bine + 14'(row.bin);
        mexp <= mexp_left;
      end
    end
    if (cmd.pack1_en) begin
      pk_mant <= wj;
      pk_exp  <= pe[10:0];
      pk_cls  <= CLS_NORMAL;
      if (pe >= 14'sd2047) begin
        pk_cls <= CLS_INF;
      end else if (pe < 14'sd1) begin
        pk_exp <= '0;
        if (pe < -14'sd52) begin
          pk_cls <= CLS_ZERO;
        end else begin
          pk_mant <= (wj >> dn) | {63'b0, |(wj & jmask)};
        end
      end
    end
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((accept && emit && !emit_scale) || cmd.pack2_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pack2_en) begin
      value_bits <= rnd_bits;
      end_offset <= sc_offset;
      converted  <= 1'b1;
    end else if (accept && emit && !emit_scale) begin
      value_bits <= direct_bits;
      end_offset <= emit_ok ? end_next : '0;
      converted  <= emit_ok;
    end
  end

endmodule

// ===== rtl/decimal_text_to_binary64.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_binary64
// Throughput: one character per cycle while parsing and the output is free.
// Result: registered directly from the ending character when no scaling is
//   needed, else after the normalize, row select, multiply and pack steps;
//   the shared 32x32 multiplier (six partial products per table row) sets
//   the ending cost.
// Reset: synchronous rst returns the parser to leading space, drops results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module decimal_text_to_binary64
  import dttb_pkg::*;
#(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              char_code,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [63:0]             value_bits,
  output logic [OFFSET_WIDTH-1:0] end_offset,
  output logic                    converted
);

  cmd_t  cmd;
  stat_t st;

  // sequence the final scaling
  dttb_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  // parse, scale and pack
  dttb_dp #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value_bits (value_bits),
    .end_offset (end_offset),
    .converted  (converted)
  );

  `ASSERT_CLK(a_ready_needs_room, clk, rst, in_ready |-> (!out_valid || out_ready), "input taken while output full")
  `ASSERT_CLK(a_fail_is_zero, clk, rst, (out_valid && !converted) |-> (value_bits == 64'b0 && end_offset == '0), "failed transaction carries data")
  `ASSERT_CLK(a_no_nan, clk, rst, (out_valid && value_bits[62:52] == 11'h7FF) |-> (value_bits[51:0] == 52'b0), "result is NaN")

endmodule

// ===== dv/decimal_text_to_binary64_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_binary64_checker
// Watches both channels of the converter. It parses each accepted character
// with its own copy of the parser state, works out the binary64 result of
// each finished number and compares it, field by field, with the block.
// ----------------------------------------------------------------------------
module decimal_text_to_binary64_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] value_bits,
  input  logic [15:0] end_offset,
  input  logic        converted,
  output int          errors,
  output int          pending
);

  typedef enum logic [2:0] {
    P_SPACE, P_INT, P_FRACT, P_EMARK, P_EFIRST, P_EDIG
  } phase_e;

  typedef struct packed {
    logic [63:0] bits;
    logic [15:0] offs;
    logic        ok;
  } number_t;

  localparam logic [63:0] MANT_MAX  = 64'h1999_9999_9999_9998;
  localparam int          DEXP_HI   = 524287;
  localparam int          DEXP_LO   = -524288;
  localparam int          F20_MAX   = 1048575;
  localparam int          OFFS_MAX  = 65535;
  localparam logic [63:0] INF_BITS  = 64'h7FF0_0000_0000_0000;

  // parser state
  phase_e      phase;
  bit          neg;
  logic [63:0] mant;
  int          dexp;
  bit          sticky;
  bit          seen;
  bit          eneg;
  int          eacc;
  int          elim;
  int          ccount;
  int          emark;

  number_t expected_numbers[$];

  assign pending = expected_numbers.size();

  function automatic logic [63:0] pack_bits(logic [63:0] m, longint e);
    logic [63:0] rem, r;
    e += 1023;
    if (e >= 2047) return INF_BITS;
    if (e < 1) begin
      if (e < -52) return 64'd0;
      while (e <= 0) begin
        m = (m >> 1) | (m & 64'd1);
        e++;
      end
      e = 0;
    end
    rem = m & 64'h7FF;
    r = (m & {1'b0, {63{1'b1}}}) >> 11;
    rem |= r & 64'd1;
    r |= 64'(e) << 52;
    if (rem > 64'h400) r += 64'd1;
    return r;
  endfunction

  // scale by 72-bit powers of ten, then round
  function automatic logic [63:0] scale_pow10(logic [63:0] m, int de, bit stk);
    logic [63:0]  w1, w0, hm, add, lo, hi;
    logic [127:0] p;
    logic [7:0]   lo8;
    int           bine, lz, i, dec, bpow;
    bit           down;
    int           mexp;
    w1 = m;
    w0 = '0;
    bine = 63;
    down = de < 0;
    mexp = down ? -de : de;
    forever begin
      lz = 0;
      while (lz < 64 && !w1[63 - lz]) lz++;
      bine -= lz;
      if (lz > 0 && lz < 64) begin
        w1 = (w1 << lz) | (w0 >> (64 - lz));
        w0 = w0 << lz;
      end
      if (mexp == 0) break;
      // pick the coarsest row that fits
      i = 0;
      forever begin
        case ({down, 2'(i)})
          3'b000: begin hm = 64'hFC6F_7C40_4581_2296; lo8 = 8'h4D; dec = 31; bpow = 103; end
          3'b001: begin hm = 64'hFA00_0000_0000_0000; lo8 = 8'h00; dec = 3;  bpow = 10;  end
          3'b010: begin hm = 64'hA000_0000_0000_0000; lo8 = 8'h00; dec = 1;  bpow = 4;   end
          3'b100: begin hm = 64'hE45C_10C4_2A2B_3B05; lo8 = 8'h8D; dec = 44; bpow = -146; end
          3'b101: begin hm = 64'hD6BF_94D5_E57A_42BC; lo8 = 8'h3D; dec = 7;  bpow = -23; end
          default: begin hm = 64'hCCCC_CCCC_CCCC_CCCC; lo8 = 8'hCD; dec = 1; bpow = -3; end
        endcase
        if (i < 2 && dec > mexp) i++;
        else break;
      end
      do begin
        p = 128'(w1) * 128'(hm);
        hi = p[127:64];
        lo = p[63:0];
        add = (w1 >> 8) * 64'(lo8);
        lo += add;
        if (lo < add) hi += 64'd1;
        add = (w0 >> 32) * 64'(hm[63:32]);
        lo += add;
        if (lo < add) hi += 64'd1;
        w0 = lo;
        w1 = hi;
        bine += bpow;
        mexp -= dec;
      end while (mexp >= dec);
    end
    if ((w0 >> 54) != 0) w1 |= 64'd1;
    if (stk) w1 |= 64'd1;
    return pack_bits(w1, bine);
  endfunction

  task automatic clear_parser();
    phase = P_SPACE; neg = 0; mant = '0; dexp = 0; sticky = 0; seen = 0;
    eneg = 0; eacc = 0; elim = 0; ccount = 0; emark = 0;
  endtask

  task automatic arm_limit(bit n);
    longint lim;
    eneg = n;
    lim = n ? 345 + longint'(dexp) : 310 - longint'(dexp);
    if (lim < 0) lim = 0;
    if (lim > F20_MAX) lim = F20_MAX;
    elim = int'(lim);
    eacc = 0;
  endtask

  // close the number and queue its result
  task automatic finish_number(bit ok, bit with_exp);
    number_t r;
    longint  e;
    r = '0;
    if (ok) begin
      e = dexp;
      if (with_exp) e = eneg ? e - eacc : e + eacc;
      if (mant != 0) begin
        if (e <= -345) r.bits = '0;
        else if (e >= 310) r.bits = INF_BITS;
        else r.bits = scale_pow10(mant, int'(e), sticky);
      end
      if (neg) r.bits[63] = 1'b1;
      r.offs = 16'(emark);
      r.ok = 1'b1;
    end
    expected_numbers.push_back(r);
    clear_parser();
  endtask

  task automatic parse_char(logic [7:0] c);
    int     pos;
    bit     isdig;
    int     d;
    longint e;
    pos = ccount;
    if (ccount < OFFS_MAX) ccount++;
    isdig = c >= "0" && c <= "9";
    d = int'(c) - 48;
    if (phase == P_SPACE) begin
      if (c >= 1 && c <= 32) return;
      phase = P_INT;
      if (c == "+") return;
      if (c == "-") begin
        neg = 1;
        return;
      end
    end
    if (phase == P_EMARK) begin
      phase = P_EFIRST;
      if (c == "+") begin
        arm_limit(0);
        return;
      end
      if (c == "-") begin
        arm_limit(1);
        return;
      end
      arm_limit(0);
    end
    if (phase == P_INT || phase == P_FRACT) begin
      if (isdig) begin
        e = dexp;
        seen = 1;
        if (phase == P_INT) e += 1;
        if (mant <= MANT_MAX) begin
          mant = mant * 10 + 64'(d);
          e -= 1;
        end else if (d != 0) begin
          sticky = 1;
        end
        dexp = e > DEXP_HI ? DEXP_HI : (e < DEXP_LO ? DEXP_LO : int'(e));
        return;
      end
      if (phase == P_INT && c == ".") begin
        phase = P_FRACT;
        return;
      end
      if (!seen) begin
        finish_number(0, 0);
        return;
      end
      emark = pos;
      if (c == "e" || c == "E") begin
        phase = P_EMARK;
        return;
      end
      finish_number(1, 0);
      return;
    end
    if (phase == P_EFIRST || phase == P_EDIG) begin
      if (isdig) begin
        if (eacc <= elim) begin
          e = longint'(eacc) * 10 + d;
          eacc = e > F20_MAX ? F20_MAX : int'(e);
        end
        phase = P_EDIG;
        return;
      end
      if (phase == P_EDIG) begin
        emark = pos;
        finish_number(1, 1);
        return;
      end
      finish_number(1, 0);
      return;
    end
    clear_parser();
  endtask

  // compare results, then advance the parser on each input transaction
  always @(posedge clk) begin
    number_t x;
    if (rst) begin
      clear_parser();
      expected_numbers.delete();
      errors <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_numbers.size() == 0) begin
          $display("%0t: unexpected result bits %h offset %0d converted %0d",
                   $time, value_bits, end_offset, converted);
          errors <= errors + 1;
        end else begin
          x = expected_numbers.pop_front();
          if (value_bits !== x.bits || end_offset !== x.offs || converted !== x.ok) begin
            $display("%0t: result mismatch expected bits %h offset %0d converted %0d",
                     $time, x.bits, x.offs, x.ok);
            $display("%0t:                 actual bits %h offset %0d converted %0d",
                     $time, value_bits, end_offset, converted);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && in_ready) parse_char(char_code);
    end
  end

endmodule

// ===== dv/tb_decimal_text_to_binary64.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_text_to_binary64
// Feeds number text to the converter: directed edge cases, then random
// numbers with noise, under three idling mixes. The checker judges results.
// ----------------------------------------------------------------------------
module tb_decimal_text_to_binary64;

  localparam int LIMIT = 3000000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  char_code;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] value_bits;
  logic [15:0] end_offset;
  logic        converted;
  int          errors;
  int          pending;
  int          cycles;
  int          sent;
  int          send_idle;
  int          recv_idle;

  decimal_text_to_binary64 i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .char_code(char_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .value_bits(value_bits), .end_offset(end_offset), .converted(converted)
  );

  decimal_text_to_binary64_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .char_code(char_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .value_bits(value_bits), .end_offset(end_offset), .converted(converted),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // stall the result side at random
  always @(negedge clk) begin
    out_ready <= $urandom_range(99) >= recv_idle;
  end

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_decimal_text_to_binary64: errors");
      $finish;
    end
  end

  // hold one character until its transaction completes
  task automatic send_char(logic [7:0] c);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    char_code = c;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_text(string s);
    for (int k = 0; k < s.len(); k++) send_char(s[k]);
  endtask

  task automatic send_digits(int n);
    for (int k = 0; k < n; k++) send_char(8'("0") + 8'($urandom_range(9)));
  endtask

  // one random number, mostly well formed
  task automatic send_number();
    int     n;
    logic [7:0] t;
    if ($urandom_range(9) == 0) begin
      send_char(8'($urandom_range(255)));
      return;
    end
    n = $urandom_range(3);
    repeat (n) send_char(8'($urandom_range(1, 32)));
    case ($urandom_range(2))
      0: send_char("-");
      1: send_char("+");
      default: ;
    endcase
    n = $urandom_range(4) == 0 ? $urandom_range(18, 26) : $urandom_range(0, 6);
    send_digits(n);
    if ($urandom_range(1)) begin
      send_char(".");
      send_digits($urandom_range(0, $urandom_range(3) == 0 ? 24 : 5));
    end
    if ($urandom_range(2) == 0) begin
      send_char($urandom_range(1) ? "e" : "E");
      case ($urandom_range(3))
        0: send_char("-");
        1: send_char("+");
        default: ;
      endcase
      n = $urandom_range(5) == 0 ? $urandom_range(4, 7) : $urandom_range(0, 3);
      for (int k = 0; k < n; k++) begin
        if (k == 0 && n >= 3) send_char(8'("0") + 8'($urandom_range(1, 3)));
        else send_char(8'("0") + 8'($urandom_range(9)));
      end
    end
    // terminator: anything that is not a digit
    do t = 8'($urandom_range(255)); while (t >= "0" && t <= "9");
    send_char(t);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    char_code = '0;
    out_ready = 1'b0;
    cycles = 0;
    sent = 0;
    send_idle = 20;
    recv_idle = 55;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // directed: signs, fraction, exponents, range ends, rounding, failures
    send_text(" -12.5e-3,");
    send_text("+.5 1e x");
    send_text("1e+q-0 ");
    send_text("1e400 1e-400 ");
    send_text("4.9e-324 2.2250738585072014e-308 ");
    send_text("1.7976931348623157e308 ");
    send_text("12345678901234567890123.5 ");
    send_text("9e99999999 ");
    send_char(8'hFF);
    send_char(8'h00);
    send_text("7");
    send_char(8'h80);

    // hold off until everything is out
    drain();

    // random numbers under three idling mixes
    sent = 0;
    while (sent < 1550) begin
      if (sent > 1030) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (sent > 520) begin
        send_idle = 55;
        recv_idle = 20;
      end
      send_number();
    end
    send_char(" ");

    drain();
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("tb_decimal_text_to_binary64: clean");
    end else begin
      $display("tb_decimal_text_to_binary64: errors");
    end
    $finish;
  end

endmodule
